// ===== sv/gfpi_pkg.sv =====
`timescale 1ns / 1ps

package gfpi_pkg;

  // sequencer states, one-hot
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  // order of the operands in one reduction step
  typedef enum logic {
    DIR_KEEP = 1'b0,
    DIR_SWAP = 1'b1
  } step_dir_t;

endpackage

// ===== sv/gf2_poly_inverse.sv =====
`timescale 1ns / 1ps

// Inverse of a GF(2) polynomial modulo the modulus register, by the extended
// Euclidean algorithm. An operand is taken only when the block is idle
// (in_stall low). Once a result is handed over the block is idle again and
// can take the next operand. The work is done by the single shift-xor step
// unit, which in each cycle either cancels one leading term or lowers the
// tracked remainder degrees. A finished result sits in an output register,
// so the next operand can be taken while it waits; a run that ends while
// that register is still stalled holds until it drains. no_inverse is set,
// with inverse zero, when the operand reduces to zero, shares a factor with
// the modulus, or the modulus is a constant. The modulus is written through
// cfg_we/cfg_wdata; the user must write it only while idle, as the block
// itself does not enforce this.
module gf2_poly_inverse import gfpi_pkg::*; #(
  parameter int          DEGREE        = 8,
  parameter logic [63:0] MODULUS_RESET = 64'd283
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [DEGREE:0]   cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DEGREE-1:0] operand,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DEGREE-1:0] inverse,
  output logic              no_inverse
);

  localparam int W  = DEGREE + 1;
  localparam int DW = $clog2(W);
  localparam logic [DW-1:0] DU_INIT = DW'(DEGREE - 1);
  localparam logic [DW-1:0] DV_INIT = DW'(DEGREE);

  state_t            state;
  logic [DEGREE:0]   modulus;
  logic [W-1:0]      u;
  logic [W-1:0]      v;
  logic [W-1:0]      g1;
  logic [W-1:0]      g2;
  logic [DW-1:0]     du;
  logic [DW-1:0]     dv;
  logic              out_valid_r;
  logic [DEGREE-1:0] inverse_r;
  logic              no_inverse_r;

  logic              u_zero;
  logic              u_one;
  logic              u_top;
  logic              v_top;
  logic              mod_const;
  logic              out_free;
  logic              finish;
  step_dir_t         dir;
  logic [DW-1:0]     amount;
  logic [W-1:0]      u_next;
  logic [W-1:0]      v_next;
  logic [W-1:0]      g1_next;
  logic [W-1:0]      g2_next;

  // status of the working remainders
  assign u_zero    = (u == '0);
  assign u_one     = (u == W'(1));
  assign u_top     = u[du];
  assign v_top     = v[dv];
  assign mod_const = (modulus[DEGREE:1] == '0);
  assign out_free  = !out_valid_r || !out_stall;
  assign finish    = (state == S_RUN) && (u_zero || u_one) && out_free;

  // step direction and shift distance from the degree counters
  always_comb begin
    if (du < dv) begin
      dir    = DIR_SWAP;
      amount = dv - du;
    end else begin
      dir    = DIR_KEEP;
      amount = du - dv;
    end
  end

  gfpi_step_unit #(
    .W (W)
  ) u_step (
    .dir     (dir),
    .amount  (amount),
    .u       (u),
    .v       (v),
    .g1      (g1),
    .g2      (g2),
    .u_next  (u_next),
    .v_next  (v_next),
    .g1_next (g1_next),
    .g2_next (g2_next)
  );

  // sequencer, working registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      modulus     <= MODULUS_RESET[DEGREE:0];
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        modulus <= cfg_wdata;
      end
      // a new result replaces a drained one
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            // constant modulus: start from a zero remainder so it fails at once
            u     <= mod_const ? '0 : {1'b0, operand};
            v     <= modulus;
            g1    <= W'(1);
            g2    <= '0;
            du    <= DU_INIT;
            dv    <= DV_INIT;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          priority if (u_zero || u_one) begin
            if (out_free) begin
              inverse_r    <= u_one ? g1[DEGREE-1:0] : '0;
              no_inverse_r <= u_zero;
              state        <= S_IDLE;
            end
          end else if (!u_top || !v_top) begin
            // bring the degree counters down to the leading terms
            if (!u_top) begin
              du <= du - DW'(1);
            end
            if (!v_top) begin
              dv <= dv - DW'(1);
            end
          end else begin
            u  <= u_next;
            v  <= v_next;
            g1 <= g1_next;
            g2 <= g2_next;
            if (dir == DIR_SWAP) begin
              du <= dv;
              dv <= du;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall   = (state != S_IDLE);
  assign out_valid  = out_valid_r;
  assign inverse    = inverse_r;
  assign no_inverse = no_inverse_r;

  // an accepted operand always starts a run
  a_accept_runs : assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_RUN)
    else $error("accepted operand did not start a run");

  // the divisor remainder never vanishes while work is left
  a_v_nonzero : assert property (@(posedge clk) disable iff (rst)
    state == S_RUN && !u_zero |-> v != '0)
    else $error("divisor remainder became zero");

  // a failed inversion reports zero
  a_fail_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && no_inverse |-> inverse == '0)
    else $error("nonzero inverse with no_inverse set");

  // a found inverse is never zero
  a_inv_nonzero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !no_inverse |-> inverse != '0)
    else $error("zero inverse reported as valid");

endmodule

// ===== sv/gfpi_step_unit.sv =====
`timescale 1ns / 1ps

// one euclid step: shift-and-xor on the remainder pair and the cofactor pair
module gfpi_step_unit import gfpi_pkg::*; #(
  parameter int W = 9
) (
  input  step_dir_t            dir,
  input  logic [$clog2(W)-1:0] amount,
  input  logic [W-1:0]         u,
  input  logic [W-1:0]         v,
  input  logic [W-1:0]         g1,
  input  logic [W-1:0]         g2,
  output logic [W-1:0]         u_next,
  output logic [W-1:0]         v_next,
  output logic [W-1:0]         g1_next,
  output logic [W-1:0]         g2_next
);

  logic [W-1:0] rem_base;
  logic [W-1:0] rem_shift;
  logic [W-1:0] cof_base;
  logic [W-1:0] cof_shift;

  // pick which operand is shifted; on swap the lower-degree one moves up
  always_comb begin
    unique case (dir)
      DIR_SWAP: begin
        rem_base  = v;
        rem_shift = u;
        cof_base  = g2;
        cof_shift = g1;
      end
      DIR_KEEP: begin
        rem_base  = u;
        rem_shift = v;
        cof_base  = g1;
        cof_shift = g2;
      end
      default: begin
        rem_base  = u;
        rem_shift = v;
        cof_base  = g1;
        cof_shift = g2;
      end
    endcase
  end

  // cancel the leading term, apply the same update to the cofactors
  assign u_next  = rem_base ^ (rem_shift << amount);
  assign g1_next = cof_base ^ (cof_shift << amount);
  assign v_next  = rem_shift;
  assign g2_next = cof_shift;

endmodule
